@@ hdl/ppbc_pkg.sv @@
package ppbc_pkg;

    localparam int KIND_W    = 2;
    localparam int TBL_NUM_W = 6;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int PAD_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 3;
    localparam int SEL_SRC_W = 16;
    localparam int MOD_CNT_W = $clog2(SEL_SRC_W);

    localparam int PPBC_MAX_TABLES = 64;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PAD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_C    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_D    = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic mem_wr;
        logic load_seed;
        logic pos_clear;
        logic data_latch;
        logic rd_in;
        logic rd_held;
        logic mod_start;
        logic mod_step;
        logic out_load;
        logic gen_a;
        logic gen_b;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic sel_valid;
        logic mod_last;
        logic pos_last;
        logic out_blocked;
    } t_sts;

    function automatic int tbl_bits(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] x, int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

@@ hdl/ppbc_req_if.sv @@
interface ppbc_req_if import ppbc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [TBL_NUM_W-1:0] table_number;
    logic [BYTE_W-1:0]    entry_position;
    logic [BYTE_W-1:0]    entry_value;
    logic [BYTE_W-1:0]    data_byte;

    modport source (
        output valid, kind, table_number, entry_position, entry_value, data_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, table_number, entry_position, entry_value, data_byte,
        output ready
    );
endinterface

@@ hdl/ppbc_rsp_if.sv @@
interface ppbc_rsp_if import ppbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] result_byte;

    modport source (
        output valid, result_byte,
        input  ready
    );
    modport sink (
        input  valid, result_byte,
        output ready
    );
endinterface

@@ hdl/permutation_pad_byte_cipher.sv @@
// Byte stream cipher over a set of 256-entry byte permutation tables, keyed by a
// xoshiro256** generator. A load request writes a forward entry and its inverse;
// the tables are not cleared at reset and every entry a data byte may reach must be
// loaded first. A restart request loads the seed, then advances the generator. A
// data byte is a table read, then the result goes into the output register once an
// earlier result has been taken, which lets the next request in while it waits. The
// table select (low 16 bits of the current word modulo the clamped pad_count) is
// cached; the first byte after a restart, a new generator word or a pad_count write
// first runs the one-bit-a-cycle remainder loop and its table read. After the eighth
// byte of each word the generator advances. The user must write configuration only
// while no request is in flight; the block itself does not enforce this.
module permutation_pad_byte_cipher import ppbc_pkg::*; #(
    parameter int MAX_TABLES = PPBC_MAX_TABLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ppbc_req_if.sink             i_req,
    ppbc_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_req.ready = in_ready;

    ppbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_kind  (i_req.kind),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppbc_dpath #(
        .MAX_TABLES (MAX_TABLES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_table_number   (i_req.table_number),
        .i_entry_position (i_req.entry_position),
        .i_entry_value    (i_req.entry_value),
        .i_data_byte      (i_req.data_byte),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_result_byte    (o_rsp.result_byte)
    );

    // table writes only come from an accepted load request
    a_wr_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_wr |-> (i_req.valid && in_ready && (i_req.kind == KIND_LOAD)))
        else $error("table write without a load request");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("result register overwritten");

    // generator advance runs both halves back to back
    a_gen_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.gen_a |=> cmd.gen_b)
        else $error("generator advance split");

    // no new request during the remainder loop, held table read or generator advance
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mod_step || cmd.rd_held || cmd.gen_a || cmd.gen_b) |-> !in_ready)
        else $error("request accepted while busy");

endmodule

@@ hdl/ppbc_tables.sv @@
module ppbc_tables import ppbc_pkg::*; #(
    parameter int MAX_TABLES = PPBC_MAX_TABLES
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [tbl_bits(MAX_TABLES)-1:0]      i_wr_tbl,
    input  logic [BYTE_W-1:0]                    i_wr_pos,
    input  logic [BYTE_W-1:0]                    i_wr_val,
    input  logic                                 i_rd_en,
    input  logic [tbl_bits(MAX_TABLES)+BYTE_W-1:0] i_rd_addr,
    output logic [BYTE_W-1:0]                    o_fwd,
    output logic [BYTE_W-1:0]                    o_inv
);

    localparam int DEPTH = MAX_TABLES * (2 ** BYTE_W);

    logic [BYTE_W-1:0] r_fwd_mem [DEPTH];
    logic [BYTE_W-1:0] r_inv_mem [DEPTH];
    logic [BYTE_W-1:0] r_fwd_rd;
    logic [BYTE_W-1:0] r_inv_rd;

    // a load writes the entry and its inverse in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_mem[{i_wr_tbl, i_wr_pos}] <= i_wr_val;
            r_inv_mem[{i_wr_tbl, i_wr_val}] <= i_wr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_rd <= r_fwd_mem[i_rd_addr];
            r_inv_rd <= r_inv_mem[i_rd_addr];
        end
    end

    assign o_fwd = r_fwd_rd;
    assign o_inv = r_inv_rd;

endmodule

@@ hdl/ppbc_ctrl.sv @@
module ppbc_ctrl import ppbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_in_kind,
    output logic              o_in_ready,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD    = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_RESULT = 3'd3;
    localparam logic [2:0] S_GEN_A  = 3'd4;
    localparam logic [2:0] S_GEN_B  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_kind)
                        KIND_LOAD: begin
                            o_cmd.mem_wr = 1'b1;
                        end
                        KIND_RESTART: begin
                            o_cmd.load_seed = 1'b1;
                            o_cmd.pos_clear = 1'b1;
                            n_state         = S_GEN_A;
                        end
                        KIND_DATA: begin
                            o_cmd.data_latch = 1'b1;
                            // cached table select lets the read start with the request
                            if (i_sts.sel_valid) begin
                                o_cmd.rd_in = 1'b1;
                                n_state     = S_RESULT;
                            end else begin
                                o_cmd.mod_start = 1'b1;
                                n_state         = S_MOD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_held = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.pos_last ? S_GEN_A : S_IDLE;
                end
            end
            S_GEN_A: begin
                o_cmd.gen_a = 1'b1;
                n_state     = S_GEN_B;
            end
            S_GEN_B: begin
                o_cmd.gen_b = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/ppbc_dpath.sv @@
module ppbc_dpath import ppbc_pkg::*; #(
    parameter int MAX_TABLES = PPBC_MAX_TABLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic [TBL_NUM_W-1:0] i_table_number,
    input  logic [BYTE_W-1:0]    i_entry_position,
    input  logic [BYTE_W-1:0]    i_entry_value,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_result_byte
);

    localparam int TBL_W = tbl_bits(MAX_TABLES);

    logic [PAD_W-1:0]     r_pad_count;
    logic                 r_dir;
    logic [WORD_W-1:0]    r_seed [4];
    logic [WORD_W-1:0]    r_gen [4];
    logic [WORD_W-1:0]    r_mul5;
    logic [WORD_W-1:0]    r_cur;
    logic [POS_W-1:0]     r_pos;
    logic [BYTE_W-1:0]    r_data;
    logic [TBL_W-1:0]     r_sel;
    logic                 r_sel_valid;
    logic [SEL_SRC_W-1:0] r_div_src;
    logic [PAD_W-1:0]     r_rem;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;

    logic [PAD_W-1:0]     count;
    logic [PAD_W:0]       trial;
    logic [PAD_W-1:0]     n_rem;
    logic [BYTE_W-1:0]    key;
    logic [BYTE_W-1:0]    rd_src;
    logic [BYTE_W-1:0]    rd_idx;
    logic                 wr_en;
    logic [BYTE_W-1:0]    fwd_rd;
    logic [BYTE_W-1:0]    inv_rd;
    logic [WORD_W-1:0]    s2x;
    logic [WORD_W-1:0]    s3x;
    logic [WORD_W-1:0]    rot;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_count <= PAD_W'(1);
            r_dir       <= 1'b0;
            r_seed[0]   <= '0;
            r_seed[1]   <= '0;
            r_seed[2]   <= '0;
            r_seed[3]   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PAD_COUNT: r_pad_count <= i_cfg_data[PAD_W-1:0];
                REG_DIRECTION: r_dir       <= i_cfg_data[0];
                REG_SEED_A:    r_seed[0]   <= i_cfg_data;
                REG_SEED_B:    r_seed[1]   <= i_cfg_data;
                REG_SEED_C:    r_seed[2]   <= i_cfg_data;
                REG_SEED_D:    r_seed[3]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero counts as one, large counts saturate at the table count
    always_comb begin
        if (r_pad_count == '0) begin
            count = PAD_W'(1);
        end else if (32'(r_pad_count) > MAX_TABLES) begin
            count = PAD_W'(MAX_TABLES);
        end else begin
            count = r_pad_count;
        end
    end

    // ---------------- table select: restoring remainder, one bit a cycle ----------------
    assign trial = {r_rem, r_div_src[SEL_SRC_W-1]};
    assign n_rem = (trial >= {1'b0, count}) ? PAD_W'(trial - {1'b0, count}) : PAD_W'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt   <= '0;
            r_sel_valid <= 1'b0;
        end else begin
            if (i_cmd.mod_start) begin
                r_mod_cnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt + 1'b1;
            end
            if (i_cmd.mod_step && (r_mod_cnt == '1)) begin
                r_sel_valid <= 1'b1;
            end else if (i_cmd.gen_b || (i_cfg_we && (i_cfg_idx == REG_PAD_COUNT))) begin
                r_sel_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_div_src <= r_cur[SEL_SRC_W-1:0];
            r_rem     <= '0;
        end else if (i_cmd.mod_step) begin
            r_div_src <= r_div_src << 1;
            r_rem     <= n_rem;
        end
        if (i_cmd.mod_step && (r_mod_cnt == '1)) begin
            r_sel <= TBL_W'(n_rem);
        end
    end

    // ---------------- generator ----------------
    assign s2x = r_gen[2] ^ r_gen[0];
    assign s3x = r_gen[3] ^ r_gen[1];
    assign rot = rotl64(r_mul5, 7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen[0] <= '0;
            r_gen[1] <= '0;
            r_gen[2] <= '0;
            r_gen[3] <= '0;
            r_cur    <= '0;
            r_pos    <= '0;
        end else begin
            if (i_cmd.load_seed) begin
                r_gen[0] <= r_seed[0];
                r_gen[1] <= r_seed[1];
                r_gen[2] <= r_seed[2];
                r_gen[3] <= r_seed[3];
            end else if (i_cmd.gen_a) begin
                r_gen[0] <= r_gen[0] ^ s3x;
                r_gen[1] <= r_gen[1] ^ s2x;
                r_gen[2] <= s2x ^ (r_gen[1] << 17);
                r_gen[3] <= rotl64(s3x, 45);
            end
            // scrambler output: times 9 after the rotate, second half of the advance
            if (i_cmd.gen_b) begin
                r_cur <= rot + (rot << 3);
            end
            if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.out_load) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // times 5 of the old word 1, taken while the state words update
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_a) begin
            r_mul5 <= r_gen[1] + (r_gen[1] << 2);
        end
    end

    // ---------------- tables ----------------
    assign key    = r_cur[{r_pos, 3'b000} +: BYTE_W];
    assign rd_src = i_cmd.rd_in ? i_data_byte : r_data;
    assign rd_idx = r_dir ? rd_src : (rd_src ^ key);
    assign wr_en  = i_cmd.mem_wr && (32'(i_table_number) < MAX_TABLES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_latch) begin
            r_data <= i_data_byte;
        end
    end

    ppbc_tables #(
        .MAX_TABLES (MAX_TABLES)
    ) u_tables (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_tbl  (TBL_W'(i_table_number)),
        .i_wr_pos  (i_entry_position),
        .i_wr_val  (i_entry_value),
        .i_rd_en   (i_cmd.rd_in | i_cmd.rd_held),
        .i_rd_addr ({r_sel, rd_idx}),
        .o_fwd     (fwd_rd),
        .o_inv     (inv_rd)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= r_dir ? (inv_rd ^ key) : fwd_rd;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_byte = r_out_byte;

    assign o_sts.sel_valid   = r_sel_valid;
    assign o_sts.mod_last    = (r_mod_cnt == '1);
    assign o_sts.pos_last    = (r_pos == '1);
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;

endmodule
